### design/vff_pkg.sv
`default_nettype none
package vff_pkg;

  localparam int WORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int CFG_INDEX_WIDTH = 2;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_VISCOSITY    = 2'd0,
    REG_CONDUCTIVITY = 2'd1
  } cfg_reg_t;

  localparam int PIPE_DEPTH = 8;

endpackage
`default_nettype wire

### design/viscous_face_flux_top.sv
`default_nettype none
// Viscous flux through one 2D cell face, signed fixed point (Q16.16 by default).
// Input: raise start with the twelve in_ face fields; a request is taken at
// every clock edge where start is high and busy is low. busy stays low, so a
// new face may be issued every cycle.
// Output: out_valid pulses for one cycle with momentum_x, momentum_y and energy
// fluxes after the request has passed through the pipeline, in request order. The result
// stage is a fixed-length pipeline and the receiver cannot hold it off, so one
// face per cycle is sustained.
// The latency is set by the multiply chain: the stress tensor needs mu times
// the gradients, then the 2/3 term, then the projection on the normal, then the
// product with the face-averaged velocity, each multiply in its own stage.
// Configuration: cfg_index 0 writes viscosity, 1 writes conductivity (low
// WORD_WIDTH-1 bits of cfg_data are kept); other indexes are dropped. cfg_ready
// is always high. Write only while no face is in flight.
// Reset (rst_n low, synchronous) clears both registers and empties the pipeline.
// Every intermediate saturates to the word range.
module viscous_face_flux_top
  import vff_pkg::*;
#(
  parameter int WORD_WIDTH = WORD_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic signed [WORD_WIDTH-1:0] in_u_left,
  input  wire logic signed [WORD_WIDTH-1:0] in_u_right,
  input  wire logic signed [WORD_WIDTH-1:0] in_v_left,
  input  wire logic signed [WORD_WIDTH-1:0] in_v_right,
  input  wire logic signed [WORD_WIDTH-1:0] in_du_dx,
  input  wire logic signed [WORD_WIDTH-1:0] in_du_dy,
  input  wire logic signed [WORD_WIDTH-1:0] in_dv_dx,
  input  wire logic signed [WORD_WIDTH-1:0] in_dv_dy,
  input  wire logic signed [WORD_WIDTH-1:0] in_dtemp_dx,
  input  wire logic signed [WORD_WIDTH-1:0] in_dtemp_dy,
  input  wire logic signed [WORD_WIDTH-1:0] in_area_normal_x,
  input  wire logic signed [WORD_WIDTH-1:0] in_area_normal_y,
  output logic                             out_valid,
  output logic signed [WORD_WIDTH-1:0]     out_momentum_x_flux,
  output logic signed [WORD_WIDTH-1:0]     out_momentum_y_flux,
  output logic signed [WORD_WIDTH-1:0]     out_energy_flux,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  wire logic [WORD_WIDTH-1:0]       cfg_data
);

  localparam int W = WORD_WIDTH;
  localparam int F = FRAC_BITS;
  localparam logic [2*W-1:0] LIM_POS = {{(W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [2*W-1:0] LIM_NEG = LIM_POS + {{(2*W-1){1'b0}}, 1'b1};
  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] TWO_THIRDS =
    W'(((64'd2 << F) + 64'd1) / 64'd3);

  typedef logic signed [W-1:0] word_t;

  // Q-format multiply: truncate magnitude toward zero, then saturate.
  function automatic word_t qmul(input word_t a, input word_t b);
    logic [W-1:0]   ma;
    logic [W-1:0]   mb;
    logic [2*W-1:0] p;
    logic [2*W-1:0] q;
    logic           neg;
    word_t          res;
    ma  = a[W-1] ? (~a + 1'b1) : a;
    mb  = b[W-1] ? (~b + 1'b1) : b;
    neg = a[W-1] ^ b[W-1];
    p   = {{W{1'b0}}, ma} * {{W{1'b0}}, mb};
    q   = p >> F;
    if (neg) begin
      if (q >= LIM_NEG) res = WMIN;
      else res = word_t'(~q[W-1:0] + 1'b1);
    end else begin
      if (q > LIM_POS) res = WMAX;
      else res = word_t'(q[W-1:0]);
    end
    return res;
  endfunction

  function automatic word_t sat_add(input word_t a, input word_t b);
    logic [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
    return word_t'(s[W-1:0]);
  endfunction

  function automatic word_t sat_sub(input word_t a, input word_t b);
    logic [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
    return word_t'(s[W-1:0]);
  endfunction

  function automatic word_t floor_avg(input word_t a, input word_t b);
    logic [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    return word_t'(s[W:1]);
  endfunction

  // configuration
  logic [W-2:0] mu_r;
  logic [W-2:0] k_r;
  word_t        mu_w;
  word_t        k_w;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;
  assign mu_w      = {1'b0, mu_r};
  assign k_w       = {1'b0, k_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_r <= '0;
      k_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_VISCOSITY:    mu_r <= cfg_data[W-2:0];
        REG_CONDUCTIVITY: k_r  <= cfg_data[W-2:0];
        default: ;
      endcase
    end
  end

  // valid bits travel with the stages
  logic [PIPE_DEPTH-1:0] vld_r;
  logic [PIPE_DEPTH-1:0] vld_nxt;

  assign vld_nxt = {vld_r[PIPE_DEPTH-2:0], start && !busy};

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= vld_nxt;
  end

  assign out_valid = vld_r[PIPE_DEPTH-1];

  // stage 1: sums and averages
  word_t s1_div_r, s1_sxy_r, s1_ua_r, s1_va_r, s1_ux_r, s1_vy_r;
  word_t s1_tx_r, s1_ty_r, s1_ax_r, s1_ay_r;
  word_t s1_div_nxt, s1_sxy_nxt, s1_ua_nxt, s1_va_nxt;

  always_comb begin
    s1_div_nxt = sat_add(in_du_dx, in_dv_dy);
    s1_sxy_nxt = sat_add(in_du_dy, in_dv_dx);
    s1_ua_nxt  = floor_avg(in_u_left, in_u_right);
    s1_va_nxt  = floor_avg(in_v_left, in_v_right);
  end

  always_ff @(posedge clk) begin
    s1_div_r <= s1_div_nxt;
    s1_sxy_r <= s1_sxy_nxt;
    s1_ua_r  <= s1_ua_nxt;
    s1_va_r  <= s1_va_nxt;
    s1_ux_r  <= in_du_dx;
    s1_vy_r  <= in_dv_dy;
    s1_tx_r  <= in_dtemp_dx;
    s1_ty_r  <= in_dtemp_dy;
    s1_ax_r  <= in_area_normal_x;
    s1_ay_r  <= in_area_normal_y;
  end

  // stage 2: products with mu and the temperature gradient projection
  word_t s2_md_r, s2_mux_r, s2_muy_r, s2_txy_r, s2_ptx_r, s2_pty_r;
  word_t s2_ua_r, s2_va_r, s2_ax_r, s2_ay_r;
  word_t s2_md_nxt, s2_mux_nxt, s2_muy_nxt, s2_txy_nxt, s2_ptx_nxt, s2_pty_nxt;

  always_comb begin
    s2_md_nxt  = qmul(mu_w, s1_div_r);
    s2_mux_nxt = qmul(mu_w, s1_ux_r);
    s2_muy_nxt = qmul(mu_w, s1_vy_r);
    s2_txy_nxt = qmul(mu_w, s1_sxy_r);
    s2_ptx_nxt = qmul(s1_tx_r, s1_ax_r);
    s2_pty_nxt = qmul(s1_ty_r, s1_ay_r);
  end

  always_ff @(posedge clk) begin
    s2_md_r  <= s2_md_nxt;
    s2_mux_r <= s2_mux_nxt;
    s2_muy_r <= s2_muy_nxt;
    s2_txy_r <= s2_txy_nxt;
    s2_ptx_r <= s2_ptx_nxt;
    s2_pty_r <= s2_pty_nxt;
    s2_ua_r  <= s1_ua_r;
    s2_va_r  <= s1_va_r;
    s2_ax_r  <= s1_ax_r;
    s2_ay_r  <= s1_ay_r;
  end

  // stage 3: divergence correction, doubling, heat gradient sum
  word_t s3_corr_r, s3_mux2_r, s3_muy2_r, s3_hsum_r, s3_txy_r;
  word_t s3_ua_r, s3_va_r, s3_ax_r, s3_ay_r;
  word_t s3_corr_nxt, s3_mux2_nxt, s3_muy2_nxt, s3_hsum_nxt;

  always_comb begin
    s3_corr_nxt = qmul(TWO_THIRDS, s2_md_r);
    s3_mux2_nxt = sat_add(s2_mux_r, s2_mux_r);
    s3_muy2_nxt = sat_add(s2_muy_r, s2_muy_r);
    s3_hsum_nxt = sat_add(s2_ptx_r, s2_pty_r);
  end

  always_ff @(posedge clk) begin
    s3_corr_r <= s3_corr_nxt;
    s3_mux2_r <= s3_mux2_nxt;
    s3_muy2_r <= s3_muy2_nxt;
    s3_hsum_r <= s3_hsum_nxt;
    s3_txy_r  <= s2_txy_r;
    s3_ua_r   <= s2_ua_r;
    s3_va_r   <= s2_va_r;
    s3_ax_r   <= s2_ax_r;
    s3_ay_r   <= s2_ay_r;
  end

  // stage 4: normal stresses and conduction
  word_t s4_txx_r, s4_tyy_r, s4_txy_r, s4_heat_r;
  word_t s4_ua_r, s4_va_r, s4_ax_r, s4_ay_r;
  word_t s4_txx_nxt, s4_tyy_nxt, s4_heat_nxt;

  always_comb begin
    s4_txx_nxt  = sat_sub(s3_mux2_r, s3_corr_r);
    s4_tyy_nxt  = sat_sub(s3_muy2_r, s3_corr_r);
    s4_heat_nxt = qmul(k_w, s3_hsum_r);
  end

  always_ff @(posedge clk) begin
    s4_txx_r  <= s4_txx_nxt;
    s4_tyy_r  <= s4_tyy_nxt;
    s4_heat_r <= s4_heat_nxt;
    s4_txy_r  <= s3_txy_r;
    s4_ua_r   <= s3_ua_r;
    s4_va_r   <= s3_va_r;
    s4_ax_r   <= s3_ax_r;
    s4_ay_r   <= s3_ay_r;
  end

  // stage 5: project stress on the area-weighted normal
  word_t s5_p1_r, s5_p2_r, s5_p3_r, s5_p4_r, s5_heat_r, s5_ua_r, s5_va_r;
  word_t s5_p1_nxt, s5_p2_nxt, s5_p3_nxt, s5_p4_nxt;

  always_comb begin
    s5_p1_nxt = qmul(s4_txx_r, s4_ax_r);
    s5_p2_nxt = qmul(s4_txy_r, s4_ay_r);
    s5_p3_nxt = qmul(s4_txy_r, s4_ax_r);
    s5_p4_nxt = qmul(s4_tyy_r, s4_ay_r);
  end

  always_ff @(posedge clk) begin
    s5_p1_r   <= s5_p1_nxt;
    s5_p2_r   <= s5_p2_nxt;
    s5_p3_r   <= s5_p3_nxt;
    s5_p4_r   <= s5_p4_nxt;
    s5_heat_r <= s4_heat_r;
    s5_ua_r   <= s4_ua_r;
    s5_va_r   <= s4_va_r;
  end

  // stage 6: momentum fluxes
  word_t s6_fx_r, s6_fy_r, s6_heat_r, s6_ua_r, s6_va_r;
  word_t s6_fx_nxt, s6_fy_nxt;

  always_comb begin
    s6_fx_nxt = sat_add(s5_p1_r, s5_p2_r);
    s6_fy_nxt = sat_add(s5_p3_r, s5_p4_r);
  end

  always_ff @(posedge clk) begin
    s6_fx_r   <= s6_fx_nxt;
    s6_fy_r   <= s6_fy_nxt;
    s6_heat_r <= s5_heat_r;
    s6_ua_r   <= s5_ua_r;
    s6_va_r   <= s5_va_r;
  end

  // stage 7: viscous work with the face-averaged velocity
  word_t s7_e1_r, s7_e2_r, s7_heat_r, s7_fx_r, s7_fy_r;
  word_t s7_e1_nxt, s7_e2_nxt;

  always_comb begin
    s7_e1_nxt = qmul(s6_ua_r, s6_fx_r);
    s7_e2_nxt = qmul(s6_va_r, s6_fy_r);
  end

  always_ff @(posedge clk) begin
    s7_e1_r   <= s7_e1_nxt;
    s7_e2_r   <= s7_e2_nxt;
    s7_heat_r <= s6_heat_r;
    s7_fx_r   <= s6_fx_r;
    s7_fy_r   <= s6_fy_r;
  end

  // stage 8: energy total; all three fluxes into the output registers
  word_t out_mx_r, out_my_r, out_en_r;
  word_t out_en_nxt;

  always_comb begin
    out_en_nxt = sat_add(sat_add(s7_e1_r, s7_e2_r), s7_heat_r);
  end

  always_ff @(posedge clk) begin
    out_mx_r <= s7_fx_r;
    out_my_r <= s7_fy_r;
    out_en_r <= out_en_nxt;
  end

  assign out_momentum_x_flux = out_mx_r;
  assign out_momentum_y_flux = out_my_r;
  assign out_energy_flux     = out_en_r;

endmodule
`default_nettype wire
